/* hw/rtl/mexp_pkg.sv */
// Shared types and constants for the modular exponentiation unit.
// Holds the operand width and the command/status structs between controller and datapath.
// No dependencies.
package mexp_pkg;

   // operand width used for all arithmetic (8 to 64)
   localparam int Width = 64;
   // width of the ports that carry operands and results
   localparam int FieldWidth = 64;
   localparam int CntWidth = $clog2(Width);

   typedef logic [Width-1:0] word_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic div_step;
      logic mul_setup;
      logic mul_step;
      logic mul_commit;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic n_zero;
      logic div_last;
      logic e_zero;
      logic mul_done;
   } dp_stat_type;

endpackage

/* hw/rtl/modular_exponentiation_unit.sv */
// Modular exponentiation unit: result = base ^ exponent mod modulus, one word at a time.
// Per word: base reduction by restoring division, then per exponent bit up to the highest set
// bit a setup, shift-and-add steps and a commit, then the result strobe (a zero modulus skips
// straight to it). The bit-serial modular multiplier sets the run time; a new word is taken
// once busy drops. Synchronous active-high reset returns the controller to idle and the modulus
// to 1. The result strobe lasts one cycle and cannot be stalled. Depends on mexp_pkg.
module modular_exponentiation_unit
   import mexp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [FieldWidth-1:0] req_base,
   input  logic [FieldWidth-1:0] req_exponent,
   output logic                  rsp_valid,
   output logic [FieldWidth-1:0] rsp_result,
   output logic                  rsp_div_error,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [FieldWidth-1:0] csr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   word_type    result;
   logic        div_error;
   logic [FieldWidth-1:0] modulus_ff, modulus_in;

   // modulus register, written only while idle and no word is being taken
   assign csr_ready  = !busy && !start;
   assign modulus_in = (csr_valid && csr_ready) ? csr_data : modulus_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= FieldWidth'(1);
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   mexp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .done  (rsp_valid),
      .stat  (stat),
      .cmd   (cmd)
   );

   mexp_datapath u_datapath (
      .clock     (clock),
      .cmd       (cmd),
      .stat      (stat),
      .modulus   (modulus_ff[Width-1:0]),
      .base      (req_base[Width-1:0]),
      .exponent  (req_exponent[Width-1:0]),
      .result    (result),
      .div_error (div_error)
   );

   assign rsp_result    = FieldWidth'(result);
   assign rsp_div_error = div_error;

   // result strobe is a single-cycle pulse
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // an accepted word makes the unit busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("unit not busy after accepting a word");

   // error results carry a zero value
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_error) |-> (rsp_result == '0))
      else $error("error result with nonzero value");

   // strobe only while a word is in flight
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

endmodule

/* hw/rtl/mexp_datapath.sv */
// Datapath of the modular exponentiation unit: base reduction by restoring division,
// then paired shift-and-add modular multiply (result times base, base squared).
// Depends on mexp_pkg.
module mexp_datapath
   import mexp_pkg::*;
(
   input  logic        clock,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   input  word_type    modulus,
   input  word_type    base,
   input  word_type    exponent,
   output word_type    result,
   output logic        div_error
);

   // (a + b) mod n for a, b < n
   function automatic word_type add_mod(word_type a, word_type b, word_type n);
      logic [Width:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, n}) begin
         s = s - {1'b0, n};
      end
      return s[Width-1:0];
   endfunction

   word_type dvd_ff, dvd_in;    // dividend shifting out MSB first
   word_type b_ff, b_in;        // remainder during reduce, then base power
   word_type e_ff, e_in;        // exponent, shifted right per bit
   word_type r_ff, r_in;        // running result
   word_type dbl_ff, dbl_in;    // doubled multiplicand
   word_type accr_ff, accr_in;  // result * base accumulator
   word_type accs_ff, accs_in;  // base * base accumulator
   word_type mr_ff, mr_in;      // multiplier bits for result product
   word_type ms_ff, ms_in;      // multiplier bits for square
   logic     first_ff, first_in;
   logic     use_r_ff, use_r_in;
   logic     err_ff, err_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;

   logic [Width:0] div_t;

   assign div_t = {b_ff, dvd_ff[Width-1]};

   always_comb begin
      dvd_in   = dvd_ff;
      b_in     = b_ff;
      e_in     = e_ff;
      r_in     = r_ff;
      dbl_in   = dbl_ff;
      accr_in  = accr_ff;
      accs_in  = accs_ff;
      mr_in    = mr_ff;
      ms_in    = ms_ff;
      first_in = first_ff;
      use_r_in = use_r_ff;
      err_in   = err_ff;
      cnt_in   = cnt_ff;

      // new word: zero modulus gives error and result 0
      if (cmd.load) begin
         dvd_in   = base;
         b_in     = '0;
         e_in     = exponent;
         r_in     = (modulus == '0) ? word_type'(0) : word_type'(1);
         err_in   = (modulus == '0);
         first_in = 1'b1;
         cnt_in   = CntWidth'(Width - 1);
      end

      // one restoring division step: base mod n
      if (cmd.div_step) begin
         if (div_t >= {1'b0, modulus}) begin
            b_in = word_type'(div_t - {1'b0, modulus});
         end else begin
            b_in = div_t[Width-1:0];
         end
         dvd_in = {dvd_ff[Width-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
      end

      // prepare one exponent bit; the first set bit copies the base power
      if (cmd.mul_setup) begin
         dbl_in   = b_ff;
         accr_in  = '0;
         accs_in  = '0;
         ms_in    = b_ff;
         mr_in    = '0;
         use_r_in = 1'b0;
         if (e_ff[0]) begin
            if (first_ff) begin
               r_in     = b_ff;
               first_in = 1'b0;
            end else begin
               mr_in    = r_ff;
               use_r_in = 1'b1;
            end
         end
      end

      // shift-and-add step shared by both products
      if (cmd.mul_step) begin
         if (mr_ff[0]) begin
            accr_in = add_mod(accr_ff, dbl_ff, modulus);
         end
         if (ms_ff[0]) begin
            accs_in = add_mod(accs_ff, dbl_ff, modulus);
         end
         dbl_in = add_mod(dbl_ff, dbl_ff, modulus);
         mr_in  = mr_ff >> 1;
         ms_in  = ms_ff >> 1;
      end

      // take products, move to next exponent bit
      if (cmd.mul_commit) begin
         if (use_r_ff) begin
            r_in = accr_ff;
         end
         b_in = accs_ff;
         e_in = e_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff   <= dvd_in;
      b_ff     <= b_in;
      e_ff     <= e_in;
      r_ff     <= r_in;
      dbl_ff   <= dbl_in;
      accr_ff  <= accr_in;
      accs_ff  <= accs_in;
      mr_ff    <= mr_in;
      ms_ff    <= ms_in;
      first_ff <= first_in;
      use_r_ff <= use_r_in;
      err_ff   <= err_in;
      cnt_ff   <= cnt_in;
   end

   assign stat.n_zero   = (modulus == '0);
   assign stat.div_last = (cnt_ff == '0);
   assign stat.e_zero   = (e_ff == '0);
   assign stat.mul_done = (mr_ff == '0) && (ms_ff == '0);

   assign result    = r_ff;
   assign div_error = err_ff;

endmodule

/* hw/rtl/mexp_ctrl.sv */
// Controller state machine of the modular exponentiation unit.
// Sequences load, base reduction, per-bit multiply and result strobe.
// Depends on mexp_pkg.
module mexp_ctrl
   import mexp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        done,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REDUCE = 5'b00010,
      ST_SETUP  = 5'b00100,
      ST_MULT   = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = stat.n_zero ? ST_DONE : ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (stat.e_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.mul_setup = 1'b1;
               state_in      = ST_MULT;
            end
         end
         ST_MULT: begin
            if (stat.mul_done) begin
               cmd.mul_commit = 1'b1;
               state_in       = ST_SETUP;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign done = (state_ff == ST_DONE);

endmodule
